// File: hw/rtl/assert_macros.svh
// Assertion macros used by the checker file of the completion queue.
// No dependencies; each macro expands to one labelled concurrent assertion.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Generic form: explicit clock and synchronous reset.
`define CHK_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error(msg);

// Short form for files whose clock and reset are called clock and reset.
`define CHK_ASSERT_SYNC(label, prop, msg) `CHK_ASSERT(label, clock, reset, prop, msg)

`endif

// File: hw/rtl/ioc_pkg.sv
// Shared types and codes of the in-order completion queue.
// No dependencies; used by the top level, ioc_seq, ioc_out and ioc_chk.
package ioc_pkg;

   localparam logic [1:0] CMD_NEW   = 2'd0;
   localparam logic [1:0] CMD_DONE  = 2'd1;
   localparam logic [1:0] CMD_ERROR = 2'd2;

   localparam logic [2:0] KIND_READ  = 3'd1;
   localparam logic [2:0] KIND_META  = 3'd2;
   localparam logic [2:0] KIND_WPREP = 3'd3;
   localparam logic [2:0] KIND_PFWD  = 3'd4;
   localparam logic [2:0] KIND_WRITE = 3'd5;
   localparam logic [2:0] KIND_WSYNC = 3'd6;

   localparam logic [2:0] EV_SUBMIT   = 3'd0;
   localparam logic [2:0] EV_HELD     = 3'd1;
   localparam logic [2:0] EV_RESPONSE = 3'd2;
   localparam logic [2:0] EV_SILENT   = 3'd3;
   localparam logic [2:0] EV_NONE     = 3'd4;
   localparam logic [2:0] EV_OVERFLOW = 3'd5;

   typedef struct packed {
      logic [2:0] event_res;
      logic [7:0] event_tag;
      logic       append_data;
   } result_type;

   // Sequencer to output stage: one result, or the end of an input word.
   typedef struct packed {
      logic       push;
      logic       finish;
      logic       closed;
      result_type res;
   } emit_type;

   typedef struct packed {
      logic [7:0] tag;
      logic [2:0] kind;
      logic       done;
      logic       ok;
   } qentry_type;

   typedef struct packed {
      logic [7:0] sync_tag;
      logic [7:0] wait_tag;
   } pentry_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_WSCAN_RD,
      ST_WSCAN_CHK,
      ST_SYNC_DECIDE,
      ST_PUSH,
      ST_MSCAN_RD,
      ST_MSCAN_CHK,
      ST_RET_RD,
      ST_RET_CHK,
      ST_REL_RD,
      ST_REL_CHK,
      ST_FINISH
   } seq_state_type;

   function automatic logic is_write_kind(input logic [2:0] kind);
      return (kind == KIND_WPREP) || (kind == KIND_PFWD) || (kind == KIND_WRITE);
   endfunction

endpackage

// File: hw/rtl/ioc_if.sv
// Handshake channels of the completion queue: request words in, result words out.
// No dependencies.
interface ioc_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] command;
   logic [7:0] op_tag;
   logic [2:0] op_kind;
   logic       op_ok;

   modport source (output valid, command, op_tag, op_kind, op_ok, input ready);
   modport sink   (input valid, command, op_tag, op_kind, op_ok, output ready);
endinterface

interface ioc_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] event_res;
   logic [7:0] event_tag;
   logic       append_data;
   logic       closed;
   logic       last;

   modport source (output valid, event_res, event_tag, append_data, closed, last,
                   input ready);
   modport sink   (input valid, event_res, event_tag, append_data, closed, last,
                   output ready);
endinterface

// File: hw/rtl/in_order_completion_queue_top.sv
// Channel   Direction  Words carry
// req_port  in         command, op_tag, op_kind, op_ok
// rsp_port  out        event_res, event_tag, append_data, closed, last
//
// One input word at a time; req_port.ready is high only while the sequencer idles.
// A new request is pushed; a write sync first scans the queued entries for a write.
// A completion searches the queue until a hit; after a hit it retires each done head entry,
// releases the pending syncs that wait on each retired tag, then reads the next head.
// Each step waits on the registered read of a queue RAM. Reset is synchronous; the queues
// come up empty. A stalled rsp_port holds the sequencer only in states that emit or finish.
module in_order_completion_queue_top #(
   parameter int QUEUE_DEPTH   = 16,
   parameter int PENDING_DEPTH = 8
) (
   input logic       clock,
   input logic       reset,
   ioc_req_if.sink   req_port,
   ioc_rsp_if.source rsp_port
);

   import ioc_pkg::*;

   emit_type emit;
   logic     out_can;

   ioc_seq #(.QUEUE_DEPTH(QUEUE_DEPTH), .PENDING_DEPTH(PENDING_DEPTH)) seq_i (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_port),
      .emit     (emit),
      .out_can  (out_can)
   );

   ioc_out out_i (
      .clock    (clock),
      .reset    (reset),
      .emit     (emit),
      .out_can  (out_can),
      .rsp_port (rsp_port)
   );

endmodule

// File: hw/rtl/ioc_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies; holds the order queue and the pending sync FIFO.
module ioc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

// File: hw/rtl/ioc_seq.sv
// Sequencer of the completion queue: one compare unit stepped over the order
// queue and the pending sync FIFO, both held in ioc_ram. Uses ioc_pkg, ioc_if.
module ioc_seq #(
   parameter int QUEUE_DEPTH   = 16,
   parameter int PENDING_DEPTH = 8
) (
   input  logic              clock,
   input  logic              reset,
   ioc_req_if.sink           req_port,
   output ioc_pkg::emit_type emit,
   input  logic              out_can
);

   import ioc_pkg::*;

   localparam int QW = $clog2(QUEUE_DEPTH);
   localparam int QC = $clog2(QUEUE_DEPTH + 1);
   localparam int PW = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;
   localparam int PC = $clog2(PENDING_DEPTH + 1);

   seq_state_type state_ff, state_in;

   logic [QW-1:0] q_head_ff, q_head_in, q_tail_ff, q_tail_in, ptr_ff, ptr_in;
   logic [QC-1:0] q_count_ff, q_count_in, scan_ff, scan_in;
   logic [PW-1:0] p_head_ff, p_head_in, p_tail_ff, p_tail_in;
   logic [PC-1:0] p_count_ff, p_count_in;
   logic          term_ff, term_in;
   logic [1:0]    cmd_ff, cmd_in;
   logic [7:0]    tag_ff, tag_in, wtag_ff, wtag_in, rtag_ff, rtag_in;
   logic [2:0]    kind_ff, kind_in;
   logic          ok_ff, ok_in, found_ff, found_in;

   logic          q_we;
   logic [QW-1:0] q_waddr, q_raddr;
   qentry_type    q_wdata, q_rdata;
   logic          p_we;
   logic [PW-1:0] p_waddr, p_raddr;
   pentry_type    p_wdata, p_rdata;

   logic       q_full, p_full, scan_last, mscan_hit, resp_app;
   logic [7:0] noact_tag;

   function automatic logic [QW-1:0] q_next(input logic [QW-1:0] p);
      return (p == QW'(QUEUE_DEPTH - 1)) ? '0 : p + QW'(1);
   endfunction

   function automatic logic [PW-1:0] p_next(input logic [PW-1:0] p);
      return (p == PW'(PENDING_DEPTH - 1)) ? '0 : p + PW'(1);
   endfunction

   ioc_ram #(.WIDTH($bits(qentry_type)), .DEPTH(QUEUE_DEPTH)) queue_ram (
      .clock (clock),
      .we    (q_we),
      .waddr (q_waddr),
      .wdata (q_wdata),
      .raddr (q_raddr),
      .rdata (q_rdata)
   );

   ioc_ram #(.WIDTH($bits(pentry_type)), .DEPTH(PENDING_DEPTH)) pend_ram (
      .clock (clock),
      .we    (p_we),
      .waddr (p_waddr),
      .wdata (p_wdata),
      .raddr (p_raddr),
      .rdata (p_rdata)
   );

   assign q_full    = (q_count_ff == QC'(QUEUE_DEPTH));
   assign p_full    = (p_count_ff == PC'(PENDING_DEPTH));
   assign scan_last = ((scan_ff + QC'(1)) == q_count_ff);
   assign mscan_hit = !q_rdata.done && (q_rdata.tag == tag_ff);
   assign resp_app  = ((q_rdata.kind == KIND_READ) || (q_rdata.kind == KIND_META)) &&
                      q_rdata.ok;
   assign noact_tag = (cmd_ff == CMD_ERROR) ? 8'd0 : tag_ff;

   assign req_port.ready = (state_ff == ST_IDLE);

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_port.valid) begin
               case (req_port.command)
                  CMD_NEW: begin
                     if (term_ff) begin
                        state_in = ST_FINISH;
                     end else if (req_port.op_kind == KIND_WSYNC && q_count_ff != '0) begin
                        state_in = ST_WSCAN_RD;
                     end else begin
                        state_in = ST_PUSH;
                     end
                  end
                  CMD_DONE: state_in = (q_count_ff != '0) ? ST_MSCAN_RD : ST_FINISH;
                  default:  state_in = ST_FINISH;
               endcase
            end
         end
         ST_WSCAN_RD:    state_in = ST_WSCAN_CHK;
         ST_WSCAN_CHK:   state_in = scan_last ? ST_SYNC_DECIDE : ST_WSCAN_RD;
         ST_SYNC_DECIDE: begin
            if (!found_ff) begin
               state_in = ST_PUSH;
            end else if (out_can) begin
               state_in = ST_FINISH;
            end
         end
         ST_PUSH: begin
            if (out_can) begin
               state_in = ST_FINISH;
            end
         end
         ST_MSCAN_RD:  state_in = ST_MSCAN_CHK;
         ST_MSCAN_CHK: begin
            if (mscan_hit) begin
               state_in = ST_RET_RD;
            end else begin
               state_in = scan_last ? ST_FINISH : ST_MSCAN_RD;
            end
         end
         ST_RET_RD: state_in = (q_count_ff == '0) ? ST_FINISH : ST_RET_CHK;
         ST_RET_CHK: begin
            if (!q_rdata.done) begin
               state_in = ST_FINISH;
            end else if (out_can) begin
               state_in = ST_REL_RD;
            end
         end
         ST_REL_RD: state_in = (p_count_ff == '0) ? ST_RET_RD : ST_REL_CHK;
         ST_REL_CHK: begin
            if (p_rdata.wait_tag != rtag_ff) begin
               state_in = ST_RET_RD;
            end else if (out_can) begin
               state_in = ST_REL_RD;
            end
         end
         ST_FINISH: begin
            if (out_can) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Datapath, memory ports and result words.
   always_comb begin
      q_head_in  = q_head_ff;
      q_tail_in  = q_tail_ff;
      q_count_in = q_count_ff;
      p_head_in  = p_head_ff;
      p_tail_in  = p_tail_ff;
      p_count_in = p_count_ff;
      ptr_in     = ptr_ff;
      scan_in    = scan_ff;
      term_in    = term_ff;
      cmd_in     = cmd_ff;
      tag_in     = tag_ff;
      kind_in    = kind_ff;
      ok_in      = ok_ff;
      found_in   = found_ff;
      wtag_in    = wtag_ff;
      rtag_in    = rtag_ff;

      q_we    = 1'b0;
      q_waddr = q_tail_ff;
      q_wdata = '{tag: tag_ff, kind: kind_ff, done: 1'b0, ok: 1'b0};
      q_raddr = ptr_ff;
      p_we    = 1'b0;
      p_waddr = p_tail_ff;
      p_wdata = '{sync_tag: tag_ff, wait_tag: wtag_ff};
      p_raddr = p_head_ff;

      emit     = '0;
      emit.res = '{event_res: EV_NONE, event_tag: noact_tag, append_data: 1'b0};

      case (state_ff)
         ST_IDLE: begin
            if (req_port.valid) begin
               cmd_in   = req_port.command;
               tag_in   = req_port.op_tag;
               kind_in  = req_port.op_kind;
               ok_in    = req_port.op_ok;
               ptr_in   = q_head_ff;
               scan_in  = '0;
               found_in = 1'b0;
               if (req_port.command == CMD_ERROR) begin
                  term_in = 1'b1;
               end
            end
         end
         ST_WSCAN_CHK: begin
            // The sync waits on the youngest write-type entry in the queue.
            if (is_write_kind(q_rdata.kind)) begin
               found_in = 1'b1;
               wtag_in  = q_rdata.tag;
            end
            ptr_in  = q_next(ptr_ff);
            scan_in = scan_ff + QC'(1);
         end
         ST_SYNC_DECIDE: begin
            if (found_ff && out_can) begin
               emit.push = 1'b1;
               if (p_full) begin
                  emit.res.event_res = EV_OVERFLOW;
                  emit.res.event_tag = tag_ff;
               end else begin
                  p_we       = 1'b1;
                  p_tail_in  = p_next(p_tail_ff);
                  p_count_in = p_count_ff + PC'(1);
                  emit.res.event_res = EV_HELD;
                  emit.res.event_tag = tag_ff;
               end
            end
         end
         ST_PUSH: begin
            if (out_can) begin
               emit.push          = 1'b1;
               emit.res.event_tag = tag_ff;
               if (q_full) begin
                  emit.res.event_res = EV_OVERFLOW;
               end else begin
                  q_we       = 1'b1;
                  q_tail_in  = q_next(q_tail_ff);
                  q_count_in = q_count_ff + QC'(1);
                  emit.res.event_res = EV_SUBMIT;
               end
            end
         end
         ST_MSCAN_CHK: begin
            // Oldest entry with this tag that is still open takes the completion.
            if (mscan_hit) begin
               q_we    = 1'b1;
               q_waddr = ptr_ff;
               q_wdata = '{tag: q_rdata.tag, kind: q_rdata.kind, done: 1'b1, ok: ok_ff};
            end else begin
               ptr_in  = q_next(ptr_ff);
               scan_in = scan_ff + QC'(1);
            end
         end
         ST_RET_RD: begin
            q_raddr = q_head_ff;
         end
         ST_RET_CHK: begin
            // Keep reading the head so that the data stays put during a stall.
            q_raddr = q_head_ff;
            if (q_rdata.done && out_can) begin
               emit.push          = 1'b1;
               emit.res.event_tag = q_rdata.tag;
               if (term_ff) begin
                  emit.res.event_res = EV_SILENT;
               end else begin
                  emit.res.event_res   = EV_RESPONSE;
                  emit.res.append_data = resp_app;
               end
               q_head_in  = q_next(q_head_ff);
               q_count_in = q_count_ff - QC'(1);
               rtag_in    = q_rdata.tag;
            end
         end
         ST_REL_CHK: begin
            if ((p_rdata.wait_tag == rtag_ff) && out_can) begin
               emit.push          = 1'b1;
               emit.res.event_tag = p_rdata.sync_tag;
               p_head_in          = p_next(p_head_ff);
               p_count_in         = p_count_ff - PC'(1);
               if (q_full) begin
                  emit.res.event_res = EV_OVERFLOW;
               end else begin
                  q_we       = 1'b1;
                  q_wdata    = '{tag: p_rdata.sync_tag, kind: KIND_WSYNC,
                                 done: 1'b0, ok: 1'b0};
                  q_tail_in  = q_next(q_tail_ff);
                  q_count_in = q_count_ff + QC'(1);
                  emit.res.event_res = EV_SUBMIT;
               end
            end
         end
         ST_FINISH: begin
            if (out_can) begin
               emit.finish = 1'b1;
               emit.closed = term_ff && (q_count_ff == '0);
               if (emit.closed) begin
                  p_head_in  = '0;
                  p_tail_in  = '0;
                  p_count_in = '0;
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         q_head_ff  <= '0;
         q_tail_ff  <= '0;
         q_count_ff <= '0;
         p_head_ff  <= '0;
         p_tail_ff  <= '0;
         p_count_ff <= '0;
         term_ff    <= 1'b0;
      end else begin
         state_ff   <= state_in;
         q_head_ff  <= q_head_in;
         q_tail_ff  <= q_tail_in;
         q_count_ff <= q_count_in;
         p_head_ff  <= p_head_in;
         p_tail_ff  <= p_tail_in;
         p_count_ff <= p_count_in;
         term_ff    <= term_in;
      end
   end

   always_ff @(posedge clock) begin
      ptr_ff   <= ptr_in;
      scan_ff  <= scan_in;
      cmd_ff   <= cmd_in;
      tag_ff   <= tag_in;
      kind_ff  <= kind_in;
      ok_ff    <= ok_in;
      found_ff <= found_in;
      wtag_ff  <= wtag_in;
      rtag_ff  <= rtag_in;
   end

endmodule

// File: hw/rtl/ioc_out.sv
// Output stage of the completion queue: holds back one result until it is known
// whether it is the last of its input word, then drives the rsp channel register.
// Uses ioc_pkg and ioc_if.
module ioc_out (
   input  logic              clock,
   input  logic              reset,
   input  ioc_pkg::emit_type emit,
   output logic              out_can,
   ioc_rsp_if.source         rsp_port
);

   import ioc_pkg::*;

   result_type pend_ff, pend_in, res_ff, res_in;
   logic       pend_vld_ff, pend_vld_in, vld_ff, vld_in;
   logic       last_ff, last_in, closed_ff, closed_in;

   assign out_can = !vld_ff || rsp_port.ready;

   always_comb begin
      pend_in     = pend_ff;
      pend_vld_in = pend_vld_ff;
      res_in      = res_ff;
      vld_in      = vld_ff;
      last_in     = last_ff;
      closed_in   = closed_ff;
      if (rsp_port.ready) begin
         vld_in = 1'b0;
      end
      if (emit.push) begin
         pend_in     = emit.res;
         pend_vld_in = 1'b1;
         if (pend_vld_ff) begin
            // A newer result exists, so the held one is not the last.
            vld_in    = 1'b1;
            res_in    = pend_ff;
            last_in   = 1'b0;
            closed_in = 1'b0;
         end
      end else if (emit.finish) begin
         // Without any held result the word is answered with no action.
         vld_in      = 1'b1;
         res_in      = pend_vld_ff ? pend_ff : emit.res;
         last_in     = 1'b1;
         closed_in   = emit.closed;
         pend_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_vld_ff <= 1'b0;
         vld_ff      <= 1'b0;
      end else begin
         pend_vld_ff <= pend_vld_in;
         vld_ff      <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_ff   <= pend_in;
      res_ff    <= res_in;
      last_ff   <= last_in;
      closed_ff <= closed_in;
   end

   assign rsp_port.valid       = vld_ff;
   assign rsp_port.event_res   = res_ff.event_res;
   assign rsp_port.event_tag   = res_ff.event_tag;
   assign rsp_port.append_data = res_ff.append_data;
   assign rsp_port.closed      = closed_ff;
   assign rsp_port.last        = last_ff;

endmodule

// File: hw/rtl/ioc_chk.sv
// Port-level checks of the completion queue, bound to the top level.
// Uses ioc_pkg and assert_macros.svh.
`include "assert_macros.svh"

module ioc_chk (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [2:0] rsp_event_res,
   input logic [7:0] rsp_event_tag,
   input logic       rsp_append_data,
   input logic       rsp_closed,
   input logic       rsp_last
);

   import ioc_pkg::*;

   logic [13:0] rsp_word;

   assign rsp_word = {rsp_event_res, rsp_event_tag, rsp_append_data, rsp_closed, rsp_last};

   property p_rsp_hold;
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_word);
   endproperty

   property p_closed_last;
      rsp_valid && rsp_closed |-> rsp_last;
   endproperty

   property p_append_resp;
      rsp_valid && rsp_append_data |-> rsp_event_res == EV_RESPONSE;
   endproperty

   property p_one_at_time;
      req_valid && req_ready |=> !req_ready;
   endproperty

   `CHK_ASSERT_SYNC(a_rsp_hold, p_rsp_hold, "stalled result word changed")
   `CHK_ASSERT_SYNC(a_closed_last, p_closed_last, "closed on a word that is not last")
   `CHK_ASSERT_SYNC(a_append_resp, p_append_resp, "append data outside a response")
   `CHK_ASSERT_SYNC(a_one_at_time, p_one_at_time, "request taken while busy")

endmodule

bind in_order_completion_queue_top ioc_chk chk_i (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_port.valid),
   .req_ready       (req_port.ready),
   .rsp_valid       (rsp_port.valid),
   .rsp_ready       (rsp_port.ready),
   .rsp_event_res   (rsp_port.event_res),
   .rsp_event_tag   (rsp_port.event_tag),
   .rsp_append_data (rsp_port.append_data),
   .rsp_closed      (rsp_port.closed),
   .rsp_last        (rsp_port.last)
);

// File: tb/sv/in_order_completion_queue_top_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench of the in-order completion queue: a table of directed words, then
// random words under three idling mixes, then a connection error and the shutdown drain.
// Depends on ioc_pkg, ioc_req_if, ioc_rsp_if and in_order_completion_queue_top.
module in_order_completion_queue_top_tb;
   import ioc_pkg::*;

   localparam int QUEUE_SLOTS      = 16;
   localparam int PENDING_SLOTS    = 8;
   localparam int RANDOM_PER_PHASE = 115;
   localparam int HOLD_CYCLES      = 300;
   localparam int STALL_LIMIT      = 4000;
   localparam int TAIL_CYCLES      = 200;
   localparam int PLAN_ROWS        = 26;

   localparam logic [1:0] CMD_UNUSED = 2'd3;
   localparam logic [2:0] KIND_OTHER = 3'd0;
   localparam logic [2:0] KIND_SPARE = 3'd7;

   typedef struct packed {
      logic [1:0] cmd;
      logic [7:0] tag;
      logic [2:0] kind;
      logic       ok;
   } req_word_type;

   typedef struct packed {
      logic [2:0] res;
      logic [7:0] tag;
      logic       app;
      logic       closed;
      logic       last;
   } rsp_word_type;

   typedef struct packed {
      req_word_type word;
      logic [3:0]   reps;
      logic         typed;
      logic [2:0]   res;
   } plan_row_type;

   logic clock;
   logic reset;

   ioc_req_if req_if();
   ioc_rsp_if rsp_if();

   in_order_completion_queue_top #(
      .QUEUE_DEPTH   (QUEUE_SLOTS),
      .PENDING_DEPTH (PENDING_SLOTS)
   ) u_top (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_if),
      .rsp_port (rsp_if)
   );

   // Mirror of the block: order queue, held syncs and the shutdown flag.
   qentry_type order_q[$];
   pentry_type sync_q[$];
   logic       closing = 1'b0;

   rsp_word_type word_events[$];
   rsp_word_type due_events[$];
   int         mismatches   = 0;
   int         stall_cycles = 0;
   int         tx_idle_pct  = 0;
   int         rx_idle_pct  = 0;
   bit         hold_request = 1'b0;
   int         hold_left    = 0;

   // Repeated rows step the tag by one per word. A typed row gives its single result outright.
   plan_row_type plan_rows [PLAN_ROWS] = '{
      '{'{CMD_DONE,   8'h55, KIND_OTHER, 1'b1}, 4'd1, 1'b1, EV_NONE},
      '{'{CMD_UNUSED, 8'hAA, KIND_SPARE, 1'b0}, 4'd1, 1'b1, EV_NONE},
      '{'{CMD_NEW,    8'h00, KIND_WRITE, 1'b0}, 4'd1, 1'b1, EV_SUBMIT},
      '{'{CMD_NEW,    8'h10, KIND_WSYNC, 1'b0}, 4'd3, 1'b1, EV_HELD},
      '{'{CMD_NEW,    8'h20, KIND_READ,  1'b0}, 4'd5, 1'b1, EV_SUBMIT},
      '{'{CMD_NEW,    8'h30, KIND_META,  1'b1}, 4'd5, 1'b1, EV_SUBMIT},
      '{'{CMD_NEW,    8'h40, KIND_WPREP, 1'b0}, 4'd2, 1'b1, EV_SUBMIT},
      '{'{CMD_NEW,    8'h42, KIND_PFWD,  1'b0}, 4'd2, 1'b1, EV_SUBMIT},
      '{'{CMD_NEW,    8'hFF, KIND_SPARE, 1'b1}, 4'd1, 1'b1, EV_SUBMIT},
      // The order queue is full from here on.
      '{'{CMD_NEW,    8'h50, KIND_READ,  1'b0}, 4'd1, 1'b1, EV_OVERFLOW},
      '{'{CMD_NEW,    8'h60, KIND_WSYNC, 1'b0}, 4'd5, 1'b1, EV_HELD},
      '{'{CMD_NEW,    8'h70, KIND_WSYNC, 1'b0}, 4'd1, 1'b1, EV_OVERFLOW},
      '{'{CMD_DONE,   8'h20, KIND_OTHER, 1'b1}, 4'd1, 1'b1, EV_NONE},
      // Retiring the first write releases three syncs into one free slot.
      '{'{CMD_DONE,   8'h00, KIND_OTHER, 1'b1}, 4'd1, 1'b0, EV_NONE},
      '{'{CMD_DONE,   8'h21, KIND_OTHER, 1'b0}, 4'd4, 1'b0, EV_NONE},
      '{'{CMD_DONE,   8'h30, KIND_OTHER, 1'b1}, 4'd5, 1'b0, EV_NONE},
      '{'{CMD_DONE,   8'h40, KIND_OTHER, 1'b1}, 4'd4, 1'b0, EV_NONE},
      '{'{CMD_DONE,   8'h60, KIND_OTHER, 1'b1}, 4'd5, 1'b1, EV_NONE},
      '{'{CMD_DONE,   8'hFF, KIND_OTHER, 1'b0}, 4'd1, 1'b0, EV_NONE},
      '{'{CMD_DONE,   8'h10, KIND_OTHER, 1'b1}, 4'd1, 1'b0, EV_NONE},
      // Duplicate tags, and a sync with no write ahead of it.
      '{'{CMD_NEW,    8'h80, KIND_OTHER, 1'b0}, 4'd1, 1'b1, EV_SUBMIT},
      '{'{CMD_NEW,    8'h80, KIND_READ,  1'b0}, 4'd1, 1'b1, EV_SUBMIT},
      '{'{CMD_NEW,    8'h81, KIND_WSYNC, 1'b0}, 4'd1, 1'b1, EV_SUBMIT},
      '{'{CMD_DONE,   8'h80, KIND_OTHER, 1'b1}, 4'd1, 1'b0, EV_NONE},
      '{'{CMD_DONE,   8'h80, KIND_OTHER, 1'b1}, 4'd1, 1'b0, EV_NONE},
      '{'{CMD_DONE,   8'h81, KIND_OTHER, 1'b1}, 4'd1, 1'b0, EV_NONE}
   };

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic void add_event(logic [2:0] res, logic [7:0] tag, logic app);
      rsp_word_type ev;
      ev = '{res, tag, app, 1'b0, 1'b0};
      word_events.insert(word_events.size(), ev);
   endfunction

   // Works out the results of one accepted word into word_events and advances the mirror.
   function automatic void compute_events(req_word_type w);
      qentry_type   slot;
      qentry_type   entry_in;
      pentry_type   held;
      rsp_word_type tail_ev;
      logic         wait_found;
      logic [7:0]   wait_tag;
      int           hit;
      word_events.delete();
      wait_found = 1'b0;
      wait_tag   = 8'h00;
      hit        = -1;
      case (w.cmd)
         CMD_NEW: begin
            if (!closing) begin
               // A write sync waits on the youngest write-type entry still queued.
               if (w.kind == KIND_WSYNC) begin
                  foreach (order_q[i]) begin
                     if (order_q[i].kind == KIND_WPREP || order_q[i].kind == KIND_PFWD ||
                         order_q[i].kind == KIND_WRITE) begin
                        wait_found = 1'b1;
                        wait_tag   = order_q[i].tag;
                     end
                  end
               end
               if (wait_found) begin
                  if (sync_q.size() >= PENDING_SLOTS) begin
                     add_event(EV_OVERFLOW, w.tag, 1'b0);
                  end else begin
                     held = '{w.tag, wait_tag};
                     sync_q.insert(sync_q.size(), held);
                     add_event(EV_HELD, w.tag, 1'b0);
                  end
               end else if (order_q.size() < QUEUE_SLOTS) begin
                  entry_in = '{w.tag, w.kind, 1'b0, 1'b0};
                  order_q.insert(order_q.size(), entry_in);
                  add_event(EV_SUBMIT, w.tag, 1'b0);
               end else begin
                  add_event(EV_OVERFLOW, w.tag, 1'b0);
               end
            end
         end
         CMD_DONE: begin
            foreach (order_q[i]) begin
               if (hit < 0 && !order_q[i].done && order_q[i].tag == w.tag) hit = i;
            end
            if (hit >= 0) begin
               slot      = order_q[hit];
               slot.done = 1'b1;
               slot.ok   = w.ok;
               order_q[hit] = slot;
               while (order_q.size() > 0 && order_q[0].done) begin
                  slot = order_q[0];
                  order_q.delete(0);
                  if (closing) begin
                     add_event(EV_SILENT, slot.tag, 1'b0);
                  end else begin
                     add_event(EV_RESPONSE, slot.tag,
                               slot.ok && (slot.kind == KIND_READ || slot.kind == KIND_META));
                  end
                  while (sync_q.size() > 0 && sync_q[0].wait_tag == slot.tag) begin
                     held = sync_q[0];
                     sync_q.delete(0);
                     if (order_q.size() < QUEUE_SLOTS) begin
                        entry_in = '{held.sync_tag, KIND_WSYNC, 1'b0, 1'b0};
                        order_q.insert(order_q.size(), entry_in);
                        add_event(EV_SUBMIT, held.sync_tag, 1'b0);
                     end else begin
                        add_event(EV_OVERFLOW, held.sync_tag, 1'b0);
                     end
                  end
               end
            end
         end
         CMD_ERROR: closing = 1'b1;
         default: ;
      endcase
      if (word_events.size() == 0)
         add_event(EV_NONE, (w.cmd == CMD_ERROR) ? 8'h00 : w.tag, 1'b0);
      tail_ev        = word_events[word_events.size() - 1];
      tail_ev.closed = closing && (order_q.size() == 0);
      tail_ev.last   = 1'b1;
      // Once closed, syncs still waiting can never be released.
      if (tail_ev.closed) sync_q.delete();
      word_events[word_events.size() - 1] = tail_ev;
   endfunction

   // Tag of an unfinished entry, the head in at least two picks out of five so that runs retire.
   function automatic logic [7:0] pick_open_tag();
      int open_idx[$];
      foreach (order_q[i]) begin
         if (!order_q[i].done) open_idx.insert(open_idx.size(), i);
      end
      if ($urandom_range(99) < 40) return order_q[open_idx[0]].tag;
      return order_q[open_idx[$urandom_range(open_idx.size() - 1)]].tag;
   endfunction

   function automatic void check_field(string what, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
         $display("%0t ns: %s expected %02h, got %02h", $time, what, want, got);
         mismatches++;
      end
   endfunction

   // Offers one word from a falling edge, records its results once taken, then idles at random.
   task automatic offer(req_word_type w, logic typed, logic [2:0] typed_res);
      rsp_word_type typed_ev;
      req_if.valid   <= 1'b1;
      req_if.command <= w.cmd;
      req_if.op_tag  <= w.tag;
      req_if.op_kind <= w.kind;
      req_if.op_ok   <= w.ok;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      compute_events(w);
      if (typed) begin
         typed_ev = '{typed_res, w.tag, 1'b0, 1'b0, 1'b1};
         due_events.insert(due_events.size(), typed_ev);
      end else begin
         foreach (word_events[i]) due_events.insert(due_events.size(), word_events[i]);
      end
      @(negedge clock);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_if.valid   <= 1'b0;
         req_if.command <= 2'($urandom);
         req_if.op_tag  <= 8'($urandom);
         req_if.op_kind <= 3'($urandom);
         req_if.op_ok   <= 1'($urandom);
         @(negedge clock);
      end
   endtask

   // Result side: random back-pressure, with one long hold-off on request.
   initial begin
      rsp_if.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            hold_left--;
            rsp_if.ready <= 1'b0;
         end else if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = HOLD_CYCLES;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= ($urandom_range(99) >= rx_idle_pct);
         end
      end
   end

   always @(posedge clock) begin
      rsp_word_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (due_events.size() == 0) begin
            $display("%0t ns: unexpected result res %0d tag %02h app %0b closed %0b last %0b",
                     $time, rsp_if.event_res, rsp_if.event_tag, rsp_if.append_data,
                     rsp_if.closed, rsp_if.last);
            mismatches++;
         end else begin
            want = due_events[0];
            due_events.delete(0);
            check_field("event_res", 8'(want.res), 8'(rsp_if.event_res));
            check_field("event_tag", want.tag, rsp_if.event_tag);
            check_field("append_data", 8'(want.app), 8'(rsp_if.append_data));
            check_field("closed", 8'(want.closed), 8'(rsp_if.closed));
            check_field("last", 8'(want.last), 8'(rsp_if.last));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
         stall_cycles = 0;
      else
         stall_cycles = stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
         $display("%0t ns: no word moved for %0d cycles", $time, STALL_LIMIT);
         $display("Simulation FAILED");
         $finish;
      end
   end

   initial begin
      req_word_type w;
      logic [7:0]   fresh_tag;
      int           new_pct;
      bit           sync_storm;
      int           roll;
      int           r;
      int           k;
      int           phase;
      reset          = 1'b1;
      req_if.valid   = 1'b0;
      req_if.command = CMD_NEW;
      req_if.op_tag  = 8'h00;
      req_if.op_kind = KIND_OTHER;
      req_if.op_ok   = 1'b0;
      fresh_tag      = 8'h00;
      new_pct        = 50;
      sync_storm     = 1'b0;
      tx_idle_pct    = 21;
      rx_idle_pct    = 53;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (r = 0; r < PLAN_ROWS; r++) begin
         w = plan_rows[r].word;
         for (k = 0; k < plan_rows[r].reps; k++) begin
            offer(w, plan_rows[r].typed, plan_rows[r].res);
            w.tag = w.tag + 8'd1;
         end
      end

      // A connection error cannot be undone, so normal-mode traffic all comes first.
      for (phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               tx_idle_pct = 21;
               rx_idle_pct = 53;
            end
            1: begin
               tx_idle_pct = 53;
               rx_idle_pct = 21;
            end
            default: begin
               tx_idle_pct  = 0;
               rx_idle_pct  = 0;
               hold_request = 1'b1;
            end
         endcase
         for (k = 0; k < RANDOM_PER_PHASE; k++) begin
            // Each burst of 24 words picks at random its share of new requests and whether syncs storm.
            if (k % 24 == 0) begin
               case ($urandom_range(2))
                  0: new_pct = 25;
                  1: new_pct = 55;
                  default: new_pct = 80;
               endcase
               sync_storm = ($urandom_range(2) == 0);
            end
            w.tag  = 8'($urandom);
            w.kind = 3'($urandom);
            w.ok   = 1'($urandom);
            roll   = $urandom_range(99);
            if (roll < new_pct) begin
               w.cmd = CMD_NEW;
               if (sync_storm && $urandom_range(1)) w.kind = KIND_WSYNC;
               if ($urandom_range(99) < 85) begin
                  w.tag     = fresh_tag;
                  fresh_tag = fresh_tag + 8'd1;
               end
            end else if (roll < 94 && order_q.size() > 0) begin
               w.cmd = CMD_DONE;
               w.tag = pick_open_tag();
            end else begin
               w.cmd = $urandom_range(1) ? CMD_DONE : CMD_UNUSED;
            end
            offer(w, 1'b0, EV_NONE);
         end
      end

      // Shutdown: entries drain silently while new requests are turned away.
      w = '{CMD_ERROR, 8'hC3, KIND_SPARE, 1'b1};
      offer(w, 1'b0, EV_NONE);
      while (order_q.size() > 0) begin
         w.tag  = 8'($urandom);
         w.kind = 3'($urandom);
         w.ok   = 1'($urandom);
         case ($urandom_range(5))
            0: w.cmd = CMD_NEW;
            1: w.cmd = CMD_UNUSED;
            2: w.cmd = CMD_ERROR;
            default: begin
               w.cmd = CMD_DONE;
               w.tag = pick_open_tag();
            end
         endcase
         offer(w, 1'b0, EV_NONE);
      end
      for (k = 0; k < 4; k++) begin
         w.tag  = 8'($urandom);
         w.kind = 3'($urandom);
         w.ok   = 1'($urandom);
         case (k)
            0: w.cmd = CMD_ERROR;
            1: w.cmd = CMD_NEW;
            2: w.cmd = CMD_DONE;
            default: w.cmd = CMD_UNUSED;
         endcase
         offer(w, 1'b0, EV_NONE);
      end
      req_if.valid <= 1'b0;

      while (due_events.size() > 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatches == 0 && due_events.size() == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
